### rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros shared by the checker files.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define RPR_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rpr checker: invariant violated");

// Antecedent in this cycle implies consequent in the same cycle.
`define RPR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpr checker: same-cycle implication violated");

// Antecedent in this cycle implies consequent in the next cycle.
`define RPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpr checker: next-cycle implication violated");

`endif

### rtl/core/rpr_pkg.sv
// rpr_pkg: types, codes and helper functions of the packet receiver.
// No dependencies; used by every module of the receiver.
package rpr_pkg;

    // Protocol characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_PLUS   = 8'h2b;
    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] BYTE_MASK   = 8'hff;

    // Register map
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_MAX_PAYLOAD = 1'b0;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4095;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_DIG1    = 4'b0100,
        PH_DIG2    = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        K_BYTE    = 3'd0,
        K_GOOD    = 3'd1,
        K_CKERR   = 3'd2,
        K_OVER    = 3'd3,
        K_RESTART = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ACK_NONE  = 2'd0,
        ACK_PLUS  = 2'd1,
        ACK_MINUS = 2'd2
    } ack_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] length;
        ack_t        ack;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    // ASCII hex digit decode; ok low for anything that is not a hex digit
    function automatic hex_t hex_decode(logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.val = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

### rtl/core/rsp_packet_receiver_core.sv
// rsp_packet_receiver_core: receiving half of a remote serial debug link.
//
// Input channel: one received byte (rx_byte) per transfer, in_valid/in_stall.
// Output channel: zero or one result per byte (kind, data, length, ack),
// out_valid/out_stall. Payload bytes stream out as kind 0; the end of each
// packet gives good (ack '+'), checksum error, overflow (ack '-') or a
// restart by a start character inside the payload.
// Configuration: APB-style slave, max_payload at byte address 0; write it
// only while no byte is in flight.
//
// Results are registered: in the output register, or in the skid entry behind a
// stalled result. Throughput: one byte per cycle while in_stall is low, set by
// the single parse stage in front of the output register.
// Stall: a stalled result holds in the output register; one further result
// lands in the skid entry, and in_stall then rises until the receiver drains
// it. Bytes that give no result still need in_stall low to be taken.
// Reset: parser returns to hunting for '$', counters clear, max_payload goes
// to 4095, output and skid entries empty. No clearing pass.
// Depends on rpr_pkg, rpr_cfg, rpr_parse and rpr_outbuf.
module rsp_packet_receiver_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    // result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    kind,
    output logic [7:0]                    data,
    output logic [15:0]                   length,
    output logic [1:0]                    ack,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rpr_pkg::*;

    logic        in_fire;
    logic [15:0] max_payload;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    // a byte transfer completes when valid meets no stall
    assign in_fire = in_valid && !in_stall;

    rpr_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_payload (max_payload)
    );

    // framing, checksum and count: one byte per cycle while in_stall is low
    rpr_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .rx_byte     (rx_byte),
        .max_payload (max_payload),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register and skid entry; res_valid only counts on a transfer
    rpr_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid && in_fire),
        .res       (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind   = out_res.kind;
    assign data   = out_res.data;
    assign length = out_res.length;
    assign ack    = out_res.ack;

endmodule

### rtl/core/rpr_cfg.sv
// rpr_cfg: APB-style register slave holding the max_payload limit.
// Depends on rpr_pkg.
module rpr_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [15:0]                   max_payload
);
    import rpr_pkg::*;

    logic [15:0] max_payload_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (wr_en)
        begin
            max_payload_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAX_PAYLOAD)
        begin
            prdata = {16'd0, max_payload_reg};
        end
    end

    assign max_payload = max_payload_reg;

endmodule

### rtl/core/rpr_parse.sv
// rpr_parse: packet framing state machine, checksum and byte count.
// Depends on rpr_pkg. One byte is parsed per accepted transfer.
module rpr_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       rx_byte,
    input  logic [15:0]      max_payload,
    output logic             res_valid,
    output rpr_pkg::result_t res
);
    import rpr_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  sum_reg,    sum_next;
    logic [15:0] count_reg,  count_next;
    logic [3:0]  high_reg,   high_next;
    logic        bad_reg,    bad_next;
    hex_t        hex;
    logic        sum_match;

    assign hex       = hex_decode(rx_byte);
    assign sum_match = ({high_reg, hex.val} == sum_reg);

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        high_next  = high_reg;
        bad_next   = bad_reg;
        res_valid  = 1'b0;
        res        = '{kind: K_BYTE, data: 8'd0, length: 16'd0, ack: ACK_NONE};

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == CHAR_DOLLAR)
                begin
                    phase_next = PH_PAYLOAD;
                    sum_next   = 8'd0;
                    count_next = 16'd0;
                end
            end
            PH_PAYLOAD:
            begin
                if (count_reg >= max_payload)
                begin
                    res_valid = 1'b1;
                    res.kind  = K_OVER;
                    res.ack   = ACK_MINUS;
                    if (rx_byte == CHAR_DOLLAR)
                    begin
                        sum_next   = 8'd0;
                        count_next = 16'd0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                else if (rx_byte == CHAR_DOLLAR)
                begin
                    // start character inside payload: restart the packet
                    res_valid  = 1'b1;
                    res.kind   = K_RESTART;
                    sum_next   = 8'd0;
                    count_next = 16'd0;
                end
                else if (rx_byte == CHAR_HASH)
                begin
                    phase_next = PH_DIG1;
                end
                else
                begin
                    res_valid  = 1'b1;
                    res.data   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_reg + 16'd1;
                end
            end
            PH_DIG1:
            begin
                bad_next   = !hex.ok;
                high_next  = hex.val;
                phase_next = PH_DIG2;
            end
            PH_DIG2:
            begin
                phase_next = PH_HUNT;
                res_valid  = 1'b1;
                if (!hex.ok || bad_reg || !sum_match)
                begin
                    res.kind = K_CKERR;
                    res.ack  = ACK_MINUS;
                end
                else
                begin
                    res.kind   = K_GOOD;
                    res.length = count_reg;
                    res.ack    = ACK_PLUS;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            count_reg <= 16'd0;
            high_reg  <= 4'd0;
            bad_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            high_reg  <= high_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

### rtl/core/rpr_outbuf.sv
// rpr_outbuf: output register plus one skid entry for result transfers.
// Depends on rpr_pkg. Stall towards the input is registered.
module rpr_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  rpr_pkg::result_t res,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output rpr_pkg::result_t out_res
);
    import rpr_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

### rtl/core/rpr_checker.sv
// rpr_checker: port-level checks on the packet receiver, bound to the top.
// Depends on rpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_stall,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  data,
    input  logic [15:0] length,
    input  logic [1:0]  ack
);
    import rpr_pkg::*;

    logic ack_ok;

    // acknowledge expected for each kind of result
    assign ack_ok = ((kind == K_GOOD) && (ack == ACK_PLUS)) ||
        (((kind == K_CKERR) || (kind == K_OVER)) && (ack == ACK_MINUS)) ||
        (((kind == K_BYTE) || (kind == K_RESTART)) && (ack == ACK_NONE));

    // backpressure on input only ever follows a stalled result
    `RPR_ASSERT_SAME(a_stall_cause, in_stall, $past(out_valid && out_stall))

    // data only carries payload bytes
    `RPR_ASSERT_SAME(a_data_zero, out_valid && (kind != K_BYTE), data == 8'd0)

    // length only reported on a good packet
    `RPR_ASSERT_SAME(a_length_zero, out_valid && (kind != K_GOOD), length == 16'd0)

    // acknowledge matches the kind of result
    `RPR_ASSERT_SAME(a_ack_kind, out_valid, ack_ok)

    // a stalled result holds
    `RPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(data))

endmodule

bind rsp_packet_receiver_core rpr_checker u_rpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data      (data),
    .length    (length),
    .ack       (ack)
);

### sim/rsp_packet_receiver_core_test.sv
// Self-checking testbench for rsp_packet_receiver_core: directed and random byte streams
// against a local packet parser model, with random sender gaps and receiver stalls.
// Depends on rpr_pkg and rsp_packet_receiver_core.
`timescale 1ns / 100ps

module rsp_packet_receiver_core_test;
    import rpr_pkg::*;

    localparam int unsigned ITEM_TARGET = 950;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_MAX_PAYLOAD, 2'b00};

    typedef enum int {
        STYLE_GOOD,
        STYLE_BADSUM,
        STYLE_BADDIGIT,
        STYLE_RESTART,
        STYLE_NOISE
    } pkt_style_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BEAT
    } stall_mode_t;

    // DUT connections; every input starts at a known value
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [15:0] length;
    logic [1:0]  ack;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Parser model state, mirrors what the block should hold
    phase_t      link_phase = PH_HUNT;
    logic [7:0]  link_sum = 8'h00;
    logic [15:0] link_count = 16'h0000;
    logic [3:0]  first_digit = 4'h0;
    logic        first_bad = 1'b0;
    logic [15:0] payload_limit = MAX_PAYLOAD_RST;

    // Reports still owed by the block, oldest first
    result_t     pending_reports[$];
    result_t     head_report;

    int unsigned items_sent = 0;
    int unsigned mismatches = 0;
    int          burst_left = 0;
    int          stall_run = 0;
    stall_mode_t stall_mode = STALL_NONE;

    rsp_packet_receiver_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .data     (data),
        .length   (length),
        .ack      (ack),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void note_mismatch(input string detail);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch: %s", detail);
        end
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 carry its value
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, c[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h57)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h37)};
        end
        return 5'b0_0000;
    endfunction

    // Nibble as an ASCII hex digit, letters in random case
    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void queue_report(input kind_t k, input logic [7:0] d,
                                         input logic [15:0] n, input ack_t a);
        result_t r;
        r.kind   = k;
        r.data   = d;
        r.length = n;
        r.ack    = a;
        pending_reports.push_back(r);
    endfunction

    function automatic void open_packet();
        link_phase = PH_PAYLOAD;
        link_sum   = 8'h00;
        link_count = 16'h0000;
    endfunction

    // Advance the parser model by one accepted byte and queue what it reports
    function automatic void parse_link_byte(input logic [7:0] c);
        logic [4:0] dv;
        case (link_phase)
            PH_HUNT:
            begin
                if (c == CHAR_DOLLAR)
                begin
                    open_packet();
                end
            end
            PH_PAYLOAD:
            begin
                if (link_count >= payload_limit)
                begin
                    // limit reached: any byte ends the packet, '$' also opens a new one
                    queue_report(K_OVER, 8'h00, 16'h0000, ACK_MINUS);
                    if (c == CHAR_DOLLAR)
                    begin
                        open_packet();
                    end
                    else
                    begin
                        link_phase = PH_HUNT;
                    end
                end
                else if (c == CHAR_DOLLAR)
                begin
                    open_packet();
                    queue_report(K_RESTART, 8'h00, 16'h0000, ACK_NONE);
                end
                else if (c == CHAR_HASH)
                begin
                    link_phase = PH_DIG1;
                end
                else
                begin
                    link_sum   = link_sum + c;
                    link_count = link_count + 16'd1;
                    queue_report(K_BYTE, c, 16'h0000, ACK_NONE);
                end
            end
            PH_DIG1:
            begin
                dv          = digit_of(c);
                first_bad   = !dv[4];
                first_digit = dv[4] ? dv[3:0] : 4'h0;
                link_phase  = PH_DIG2;
            end
            default:
            begin
                dv         = digit_of(c);
                link_phase = PH_HUNT;
                if (!dv[4] || first_bad || {first_digit, dv[3:0]} != link_sum)
                begin
                    queue_report(K_CKERR, 8'h00, 16'h0000, ACK_MINUS);
                end
                else
                begin
                    queue_report(K_GOOD, 8'h00, link_count, ACK_PLUS);
                end
            end
        endcase
    endfunction

    // Receiver side: stall on a pattern that changes mode every so often
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_run  = $urandom_range(20, 200);
            end
            stall_run--;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= ((stall_run % 7) < 3);
            endcase
        end
    end

    // Every accepted result transfer is checked against the oldest owed report
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result kind %0d data %02h len %0d ack %0d",
                                        kind, data, length, ack));
            end
            else
            begin
                head_report = pending_reports.pop_front();
                if (kind !== head_report.kind || data !== head_report.data ||
                    length !== head_report.length || ack !== head_report.ack)
                begin
                    note_mismatch($sformatf({"exp kind %0d data %02h len %0d ack %0d, ",
                                             "got kind %0d data %02h len %0d ack %0d"},
                                            head_report.kind, head_report.data,
                                            head_report.length, head_report.ack,
                                            kind, data, length, ack));
                end
            end
        end
    end

    // One byte transfer. Bursts of random length with random gaps in between;
    // a gap of zero keeps valid high straight into the next burst.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 60);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_byte  <= b;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        items_sent++;
        parse_link_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // Sender goes quiet until every owed report has come or DRAIN_LIMIT runs out, then
    // allows for a byte that reports nothing still being in the parse stage
    task automatic drain_results();
        int unsigned waited;
        waited   = 0;
        in_valid <= 1'b0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // max_payload write, then read back, over the APB-style port; only when idle
    task automatic write_limit(input logic [15:0] value);
        logic [31:0] word;
        drain_results();
        word       = $urandom();
        word[15:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        payload_limit = value;
        // straight into the read setup cycle, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata[15:0] !== value)
        begin
            note_mismatch($sformatf("max_payload read exp %0d got %0d", value, prdata[15:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One packet of the given style: '$', payload free of framing characters but for
    // a restart '$', '#', then two checksum digits (correct, wrong or not hex); noise: junk
    task automatic send_packet(input int len, input pkt_style_t style);
        logic [7:0] b;
        logic [7:0] s;
        logic [4:0] dv;
        int         cut;
        int         bad_pos;
        if (style == STYLE_NOISE)
        begin
            repeat (len)
            begin
                // mostly junk between packets, now and then a stray '$'
                do
                begin
                    b = 8'($urandom_range(0, 255));
                end
                while (b == CHAR_DOLLAR && $urandom_range(0, 7) != 0);
                send_byte(b);
            end
            return;
        end
        send_byte(CHAR_DOLLAR);
        s   = 8'h00;
        cut = (style == STYLE_RESTART && len > 0) ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++)
        begin
            if (i == cut)
            begin
                send_byte(CHAR_DOLLAR);
                s = 8'h00;
            end
            do
            begin
                b = 8'($urandom_range(0, 255));
            end
            while (b == CHAR_DOLLAR || b == CHAR_HASH);
            send_byte(b);
            s = s + b;
        end
        send_byte(CHAR_HASH);
        if (style == STYLE_BADSUM)
        begin
            s = s ^ 8'($urandom_range(1, 255));
        end
        if (style == STYLE_BADDIGIT)
        begin
            bad_pos = $urandom_range(0, 1);
            do
            begin
                b  = 8'($urandom_range(0, 255));
                dv = digit_of(b);
            end
            while (dv[4]);
            send_byte((bad_pos == 0) ? b : nibble_char(s[7:4]));
            send_byte((bad_pos == 1) ? b : nibble_char(s[3:0]));
        end
        else
        begin
            send_byte(nibble_char(s[7:4]));
            send_byte(nibble_char(s[3:0]));
        end
    endtask

    // Junk while hunting, then a good packet with the byte extremes and
    // mixed-case checksum digits
    task automatic test_hunt_and_good();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(CHAR_HASH);
        send_byte(CHAR_DOLLAR);
        send_byte(8'h00);
        send_byte(8'hff);
        send_text("#fF");
    endtask

    // '$' inside the payload restarts; then an empty packet
    task automatic test_restart();
        send_text("$x$#00");
    endtask

    // Non-hex first digit, and '$' taken as the second digit
    task automatic test_bad_digits();
        send_text("$#g0");
        send_text("$#0$");
    endtask

    // Limit zero: overflow on the first byte, '$' at the limit reopens,
    // '#' at the limit still overflows
    task automatic test_overflow();
        write_limit(16'd0);
        send_text("$a$$#");
        write_limit(16'd2);
        send_text("$ab#");
    endtask

    // Limit raised mid-packet takes effect on the next byte; then the top limit
    task automatic test_limit_change();
        write_limit(16'd2);
        send_text("$ab");
        write_limit(16'd5);
        send_text("c#26");
        write_limit(16'hffff);
        send_packet(20, STYLE_GOOD);
    endtask

    // Phases of random packets, each under its own limit; every limit write
    // drains the block first
    task automatic test_random_packets();
        logic [15:0] limits [8];
        int unsigned phase_end;
        int          len;
        int          pick;
        pkt_style_t  style;
        limits = '{16'd1, 16'd3, 16'hffff, 16'd8, 16'd0, 16'd4095, 16'd20, 16'd0};
        limits[7] = 16'($urandom());
        for (int p = 0; p < 8; p++)
        begin
            write_limit(limits[p]);
            phase_end = (items_sent < ITEM_TARGET) ?
                        items_sent + (ITEM_TARGET - items_sent) / (8 - p) : items_sent;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                begin
                    style = STYLE_GOOD;
                end
                else if (pick < 14)
                begin
                    style = STYLE_BADSUM;
                end
                else if (pick < 16)
                begin
                    style = STYLE_BADDIGIT;
                end
                else if (pick < 18)
                begin
                    style = STYLE_RESTART;
                end
                else
                begin
                    style = STYLE_NOISE;
                end
                pick = $urandom_range(0, 9);
                if (style == STYLE_NOISE)
                begin
                    len = $urandom_range(1, 4);
                end
                else if (limits[p] <= 40 && pick < 4)
                begin
                    // straddle the limit: one under, exactly at it, or one over
                    len = int'(limits[p]) + $urandom_range(0, 2) - 1;
                    if (len < 0)
                    begin
                        len = 0;
                    end
                end
                else if (pick == 9)
                begin
                    len = $urandom_range(20, 60);
                end
                else
                begin
                    len = $urandom_range(0, 10);
                end
                send_packet(len, style);
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hunt_and_good();
        test_restart();
        test_bad_digits();
        test_overflow();
        test_limit_change();
        test_random_packets();
        drain_results();
        if (pending_reports.size() != 0)
        begin
            note_mismatch($sformatf("%0d results never arrived", pending_reports.size()));
        end
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/rpr_pkg.sv
rtl/core/rpr_cfg.sv
rtl/core/rpr_parse.sv
rtl/core/rpr_outbuf.sv
rtl/core/rsp_packet_receiver_core.sv
rtl/core/rpr_checker.sv
sim/rsp_packet_receiver_core_test.sv
